@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge out of reset
`define UM_ASSERT_HOLD(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define UM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/um_pkg.sv @@
package um_pkg;

    localparam int REG_W  = 32;
    localparam int REG_AW = 3;
    localparam int OP_W   = 4;
    localparam int ACT_W  = 4;

    // instruction word layout
    localparam int OPC_SHIFT     = 28;
    localparam int IMM_REG_SHIFT = 25;
    localparam int IMM_W         = 25;
    localparam logic [REG_W-1:0] OUT_LIMIT = 32'd256;

    // opcodes
    localparam logic [OP_W-1:0] OP_CMOV  = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
    localparam logic [OP_W-1:0] OP_STORE = 4'd2;
    localparam logic [OP_W-1:0] OP_ADD   = 4'd3;
    localparam logic [OP_W-1:0] OP_MUL   = 4'd4;
    localparam logic [OP_W-1:0] OP_DIV   = 4'd5;
    localparam logic [OP_W-1:0] OP_NAND  = 4'd6;
    localparam logic [OP_W-1:0] OP_HALT  = 4'd7;
    localparam logic [OP_W-1:0] OP_MAP   = 4'd8;
    localparam logic [OP_W-1:0] OP_UNMAP = 4'd9;
    localparam logic [OP_W-1:0] OP_OUT   = 4'd10;
    localparam logic [OP_W-1:0] OP_IN    = 4'd11;
    localparam logic [OP_W-1:0] OP_LPROG = 4'd12;
    localparam logic [OP_W-1:0] OP_IMM   = 4'd13;

    // result actions
    localparam logic [ACT_W-1:0] ACT_NONE    = 4'd0;
    localparam logic [ACT_W-1:0] ACT_HALT    = 4'd1;
    localparam logic [ACT_W-1:0] ACT_OUT     = 4'd2;
    localparam logic [ACT_W-1:0] ACT_LOAD    = 4'd3;
    localparam logic [ACT_W-1:0] ACT_STORE   = 4'd4;
    localparam logic [ACT_W-1:0] ACT_MAP     = 4'd5;
    localparam logic [ACT_W-1:0] ACT_UNMAP   = 4'd6;
    localparam logic [ACT_W-1:0] ACT_LPROG   = 4'd7;
    localparam logic [ACT_W-1:0] ACT_DIVZERO = 4'd8;
    localparam logic [ACT_W-1:0] ACT_BADOUT  = 4'd9;
    localparam logic [ACT_W-1:0] ACT_BADOP   = 4'd10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_STORE,
        S_DIV,
        S_DONE
    } state_t;

    // register file read request, two ports
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr0;
        logic [REG_AW-1:0] addr1;
    } rf_rd_t;

    // register file write request
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [REG_W-1:0]  data;
    } rf_wr_t;

endpackage

@@ rtl/um_regfile.sv @@
module um_regfile
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  um_pkg::rf_rd_t          rd,
    input  um_pkg::rf_wr_t          wr,
    output logic [um_pkg::REG_W-1:0] rd0_data,
    output logic [um_pkg::REG_W-1:0] rd1_data
);

    logic [um_pkg::REG_W-1:0]       mem [2**um_pkg::REG_AW];
    logic [2**um_pkg::REG_AW-1:0]   vld_reg;
    logic [um_pkg::REG_W-1:0]       rd0_reg;
    logic [um_pkg::REG_W-1:0]       rd1_reg;

    // storage array
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // written flags, unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr.en)
        begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    // registered read ports
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd0_reg <= vld_reg[rd.addr0] ? mem[rd.addr0] : '0;
            rd1_reg <= vld_reg[rd.addr1] ? mem[rd.addr1] : '0;
        end
    end

    assign rd0_data = rd0_reg;
    assign rd1_data = rd1_reg;

endmodule

@@ rtl/um_divider.sv @@
module um_divider
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [um_pkg::REG_W-1:0] dividend,
    input  logic [um_pkg::REG_W-1:0] divisor,
    output logic                     done,
    output logic [um_pkg::REG_W-1:0] quotient
);

    localparam int CNT_W = $clog2(um_pkg::REG_W);

    logic                     run_reg, run_next;
    logic                     done_reg, done_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [um_pkg::REG_W-1:0] rem_reg, rem_next;
    logic [um_pkg::REG_W-1:0] quo_reg, quo_next;
    logic [um_pkg::REG_W-1:0] dvs_reg, dvs_next;
    logic [um_pkg::REG_W:0]   shifted;
    logic [um_pkg::REG_W:0]   diff;
    logic                     ge;

    // one restoring step per cycle
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[um_pkg::REG_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        ge        = (shifted >= {1'b0, dvs_reg});
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '1;
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[um_pkg::REG_W-1:0] : shifted[um_pkg::REG_W-1:0];
            quo_next = {quo_reg[um_pkg::REG_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/um_instruction_execute_unit.sv @@
// UM32 instruction execute unit with eight 32-bit registers.
// Input channel (in_valid / in_stall): one request per item, either an
// instruction to execute (req_type 0) or the writeback of a memory reply
// (req_type 1) into the register remembered by the last load or map.
// Output channel (out_valid / out_stall): exactly one result per request,
// an action code plus the fields that action uses, all others zero.
// After a request is accepted, the unit executes on the register file read
// data, then commits and raises out_valid; the next request can be taken
// once the commit is done. A store adds a step because register a needs a
// second register file read; a divide waits while the divider retires one
// quotient bit per cycle.
// One request is in flight at a time; in_stall is high while it executes.
// A finished result sits in the output register while the next request
// is accepted; a request finishing while out_stall still holds the old
// result waits in its commit cycle, with the register file unchanged.
// Reset clears all registers to zero (through per-entry written flags, no
// clearing pass), drops any pending reply and empties the output register.
module um_instruction_execute_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [31:0] instr_word,
    input  logic [7:0]  in_byte,
    input  logic        in_eof,
    input  logic [31:0] reply_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  action,
    output logic [31:0] seg_id,
    output logic [31:0] seg_offset,
    output logic [31:0] store_word,
    output logic [7:0]  out_byte,
    output logic [31:0] jump_target,
    output logic        needs_reply
);

`include "assert_macros.svh"

    localparam int W  = um_pkg::REG_W;
    localparam int AW = um_pkg::REG_AW;

    um_pkg::state_t  state_reg, state_next;
    um_pkg::rf_rd_t  rf_rd;
    um_pkg::rf_wr_t  rf_wr;
    logic [W-1:0]    rd0_data;
    logic [W-1:0]    rd1_data;
    logic            div_start;
    logic            div_done;
    logic [W-1:0]    div_quo;

    // captured request
    logic            rtype_reg, rtype_next;
    logic [W-1:0]    instr_reg, instr_next;
    logic [7:0]      byte_reg, byte_next;
    logic            eof_reg, eof_next;
    logic [W-1:0]    reply_reg, reply_next;

    // pending reply tracking
    logic            await_reg, await_next;
    logic [AW-1:0]   pend_reg, pend_next;

    // staged result
    logic [um_pkg::ACT_W-1:0] res_act_reg, res_act_next;
    logic [W-1:0]    res_sid_reg, res_sid_next;
    logic [W-1:0]    res_soff_reg, res_soff_next;
    logic [W-1:0]    res_sw_reg, res_sw_next;
    logic [7:0]      res_ob_reg, res_ob_next;
    logic [W-1:0]    res_jt_reg, res_jt_next;
    logic            res_nr_reg, res_nr_next;
    logic            res_we_reg, res_we_next;
    logic [AW-1:0]   res_waddr_reg, res_waddr_next;
    logic [W-1:0]    res_wdata_reg, res_wdata_next;
    logic            res_setw_reg, res_setw_next;
    logic            res_clrw_reg, res_clrw_next;

    // output register
    logic                     out_valid_reg, out_valid_next;
    logic [um_pkg::ACT_W-1:0] out_act_reg, out_act_next;
    logic [W-1:0]    out_sid_reg, out_sid_next;
    logic [W-1:0]    out_soff_reg, out_soff_next;
    logic [W-1:0]    out_sw_reg, out_sw_next;
    logic [7:0]      out_ob_reg, out_ob_next;
    logic [W-1:0]    out_jt_reg, out_jt_next;
    logic            out_nr_reg, out_nr_next;

    // decoded fields
    logic [um_pkg::OP_W-1:0] op;
    logic [AW-1:0]   ra, rb, rc, rimm;
    logic [W-1:0]    imm_val;
    logic            slot_free;

    assign op      = instr_reg[um_pkg::OPC_SHIFT +: um_pkg::OP_W];
    assign ra      = instr_reg[8:6];
    assign rb      = instr_reg[5:3];
    assign rc      = instr_reg[2:0];
    assign rimm    = instr_reg[um_pkg::IMM_REG_SHIFT +: AW];
    assign imm_val = {{(W-um_pkg::IMM_W){1'b0}}, instr_reg[um_pkg::IMM_W-1:0]};
    assign slot_free = !out_valid_reg || !out_stall;

    um_regfile u_regfile
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd       (rf_rd),
        .wr       (rf_wr),
        .rd0_data (rd0_data),
        .rd1_data (rd1_data)
    );

    um_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd0_data),
        .divisor  (rd1_data),
        .done     (div_done),
        .quotient (div_quo)
    );

    // sequencer: next state, register file access and result staging
    always_comb
    begin
        state_next     = state_reg;
        in_stall       = 1'b1;
        rf_rd          = '0;
        rf_wr          = '0;
        div_start      = 1'b0;
        rtype_next     = rtype_reg;
        instr_next     = instr_reg;
        byte_next      = byte_reg;
        eof_next       = eof_reg;
        reply_next     = reply_reg;
        await_next     = await_reg;
        pend_next      = pend_reg;
        res_act_next   = res_act_reg;
        res_sid_next   = res_sid_reg;
        res_soff_next  = res_soff_reg;
        res_sw_next    = res_sw_reg;
        res_ob_next    = res_ob_reg;
        res_jt_next    = res_jt_reg;
        res_nr_next    = res_nr_reg;
        res_we_next    = res_we_reg;
        res_waddr_next = res_waddr_reg;
        res_wdata_next = res_wdata_reg;
        res_setw_next  = res_setw_reg;
        res_clrw_next  = res_clrw_reg;
        out_valid_next = out_valid_reg;
        out_act_next   = out_act_reg;
        out_sid_next   = out_sid_reg;
        out_soff_next  = out_soff_reg;
        out_sw_next    = out_sw_reg;
        out_ob_next    = out_ob_reg;
        out_jt_next    = out_jt_reg;
        out_nr_next    = out_nr_reg;

        // output register drains independently
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            um_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    rtype_next = req_type;
                    instr_next = instr_word;
                    byte_next  = in_byte;
                    eof_next   = in_eof;
                    reply_next = reply_value;
                    rf_rd.en    = 1'b1;
                    rf_rd.addr0 = instr_word[5:3];
                    rf_rd.addr1 = instr_word[2:0];
                    state_next  = um_pkg::S_EXEC;
                end
            end

            um_pkg::S_EXEC:
            begin
                res_act_next   = um_pkg::ACT_NONE;
                res_sid_next   = '0;
                res_soff_next  = '0;
                res_sw_next    = '0;
                res_ob_next    = '0;
                res_jt_next    = '0;
                res_nr_next    = 1'b0;
                res_we_next    = 1'b0;
                res_waddr_next = ra;
                res_wdata_next = '0;
                res_setw_next  = 1'b0;
                res_clrw_next  = 1'b0;
                state_next     = um_pkg::S_DONE;
                if (rtype_reg)
                begin
                    // memory reply goes to the remembered register
                    res_we_next    = await_reg;
                    res_waddr_next = pend_reg;
                    res_wdata_next = reply_reg;
                    res_clrw_next  = 1'b1;
                end
                else
                begin
                    unique case (op)
                        um_pkg::OP_CMOV:
                        begin
                            res_we_next    = (rd1_data != '0);
                            res_wdata_next = rd0_data;
                        end
                        um_pkg::OP_LOAD:
                        begin
                            res_act_next  = um_pkg::ACT_LOAD;
                            res_sid_next  = rd0_data;
                            res_soff_next = rd1_data;
                            res_nr_next   = 1'b1;
                            res_setw_next = 1'b1;
                        end
                        um_pkg::OP_STORE:
                        begin
                            res_act_next  = um_pkg::ACT_STORE;
                            res_soff_next = rd0_data;
                            res_sw_next   = rd1_data;
                            rf_rd.en      = 1'b1;
                            rf_rd.addr0   = ra;
                            rf_rd.addr1   = rc;
                            state_next    = um_pkg::S_STORE;
                        end
                        um_pkg::OP_ADD:
                        begin
                            res_we_next    = 1'b1;
                            res_wdata_next = rd0_data + rd1_data;
                        end
                        um_pkg::OP_MUL:
                        begin
                            res_we_next    = 1'b1;
                            res_wdata_next = rd0_data * rd1_data;
                        end
                        um_pkg::OP_DIV:
                        begin
                            if (rd1_data == '0)
                            begin
                                res_act_next = um_pkg::ACT_DIVZERO;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = um_pkg::S_DIV;
                            end
                        end
                        um_pkg::OP_NAND:
                        begin
                            res_we_next    = 1'b1;
                            res_wdata_next = ~(rd0_data & rd1_data);
                        end
                        um_pkg::OP_HALT:
                        begin
                            res_act_next = um_pkg::ACT_HALT;
                        end
                        um_pkg::OP_MAP:
                        begin
                            res_act_next   = um_pkg::ACT_MAP;
                            res_soff_next  = rd1_data;
                            res_nr_next    = 1'b1;
                            res_setw_next  = 1'b1;
                            res_waddr_next = rb;
                        end
                        um_pkg::OP_UNMAP:
                        begin
                            res_act_next = um_pkg::ACT_UNMAP;
                            res_sid_next = rd1_data;
                        end
                        um_pkg::OP_OUT:
                        begin
                            if (rd1_data >= um_pkg::OUT_LIMIT)
                            begin
                                res_act_next = um_pkg::ACT_BADOUT;
                            end
                            else
                            begin
                                res_act_next = um_pkg::ACT_OUT;
                                res_ob_next  = rd1_data[7:0];
                            end
                        end
                        um_pkg::OP_IN:
                        begin
                            res_we_next    = 1'b1;
                            res_waddr_next = rc;
                            res_wdata_next = eof_reg ? '1 : {{(W-8){1'b0}}, byte_reg};
                        end
                        um_pkg::OP_LPROG:
                        begin
                            res_act_next = um_pkg::ACT_LPROG;
                            res_sid_next = rd0_data;
                            res_jt_next  = rd1_data;
                        end
                        um_pkg::OP_IMM:
                        begin
                            res_we_next    = 1'b1;
                            res_waddr_next = rimm;
                            res_wdata_next = imm_val;
                        end
                        default:
                        begin
                            res_act_next = um_pkg::ACT_BADOP;
                        end
                    endcase
                end
            end

            um_pkg::S_STORE:
            begin
                // register a arrives from the second read
                res_sid_next = rd0_data;
                state_next   = um_pkg::S_DONE;
            end

            um_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    res_we_next    = 1'b1;
                    res_wdata_next = div_quo;
                    state_next     = um_pkg::S_DONE;
                end
            end

            um_pkg::S_DONE:
            begin
                // commit state and hand the result over together
                if (slot_free)
                begin
                    rf_wr.en   = res_we_reg;
                    rf_wr.addr = res_waddr_reg;
                    rf_wr.data = res_wdata_reg;
                    if (res_setw_reg)
                    begin
                        await_next = 1'b1;
                        pend_next  = res_waddr_reg;
                    end
                    else if (res_clrw_reg)
                    begin
                        await_next = 1'b0;
                    end
                    out_valid_next = 1'b1;
                    out_act_next   = res_act_reg;
                    out_sid_next   = res_sid_reg;
                    out_soff_next  = res_soff_reg;
                    out_sw_next    = res_sw_reg;
                    out_ob_next    = res_ob_reg;
                    out_jt_next    = res_jt_reg;
                    out_nr_next    = res_nr_reg;
                    state_next     = um_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = um_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= um_pkg::S_IDLE;
            await_reg     <= 1'b0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            await_reg     <= await_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rtype_reg     <= rtype_next;
        instr_reg     <= instr_next;
        byte_reg      <= byte_next;
        eof_reg       <= eof_next;
        reply_reg     <= reply_next;
        res_act_reg   <= res_act_next;
        res_sid_reg   <= res_sid_next;
        res_soff_reg  <= res_soff_next;
        res_sw_reg    <= res_sw_next;
        res_ob_reg    <= res_ob_next;
        res_jt_reg    <= res_jt_next;
        res_nr_reg    <= res_nr_next;
        res_we_reg    <= res_we_next;
        res_waddr_reg <= res_waddr_next;
        res_wdata_reg <= res_wdata_next;
        res_setw_reg  <= res_setw_next;
        res_clrw_reg  <= res_clrw_next;
        out_act_reg   <= out_act_next;
        out_sid_reg   <= out_sid_next;
        out_soff_reg  <= out_soff_next;
        out_sw_reg    <= out_sw_next;
        out_ob_reg    <= out_ob_next;
        out_jt_reg    <= out_jt_next;
        out_nr_reg    <= out_nr_next;
    end

    assign out_valid   = out_valid_reg;
    assign action      = out_act_reg;
    assign seg_id      = out_sid_reg;
    assign seg_offset  = out_soff_reg;
    assign store_word  = out_sw_reg;
    assign out_byte    = out_ob_reg;
    assign jump_target = out_jt_reg;
    assign needs_reply = out_nr_reg;

    // checks
    `UM_ASSERT_HOLD(a_rf_no_overlap, !(rf_wr.en && rf_rd.en),
        "register file read and write in the same cycle")
    `UM_ASSERT_NEXT(a_accept_to_exec, in_valid && !in_stall, state_reg == um_pkg::S_EXEC,
        "accepted request did not enter execute")
    `UM_ASSERT_HOLD(a_div_done_state, !div_done || state_reg == um_pkg::S_DIV,
        "divider finished outside of divide wait")
    `UM_ASSERT_NEXT(a_commit_pushes, state_reg == um_pkg::S_DONE && slot_free, out_valid,
        "committed request produced no result")

endmodule
